// File: hdl/etl_pkg.sv
`default_nettype none

package etl_pkg;

  typedef enum logic [4:0] {
    KindEnd    = 5'd0,
    KindError  = 5'd1,
    KindPlus   = 5'd2,
    KindMinus  = 5'd3,
    KindStar   = 5'd4,
    KindSlash  = 5'd5,
    KindPerc   = 5'd6,
    KindCaret  = 5'd7,
    KindLt     = 5'd8,
    KindGt     = 5'd9,
    KindLte    = 5'd10,
    KindGte    = 5'd11,
    KindEqu    = 5'd12,
    KindNequ   = 5'd13,
    KindAssign = 5'd14,
    KindOparen = 5'd15,
    KindCparen = 5'd16,
    KindNot    = 5'd17,
    KindNum    = 5'd18,
    KindSym    = 5'd19
  } tok_kind_e;

  typedef enum logic [2:0] {
    PendNone = 3'd0,
    PendLt   = 3'd1,
    PendGt   = 3'd2,
    PendEq   = 3'd3,
    PendBang = 3'd4,
    PendSym  = 3'd5,
    PendNum  = 3'd6
  } pend_e;

  localparam int unsigned TokLenW = 6;

  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharMinus  = 8'h2D;
  localparam logic [7:0] CharStar   = 8'h2A;
  localparam logic [7:0] CharSlash  = 8'h2F;
  localparam logic [7:0] CharPerc   = 8'h25;
  localparam logic [7:0] CharCaret  = 8'h5E;
  localparam logic [7:0] CharOparen = 8'h28;
  localparam logic [7:0] CharCparen = 8'h29;
  localparam logic [7:0] CharLt     = 8'h3C;
  localparam logic [7:0] CharGt     = 8'h3E;
  localparam logic [7:0] CharEq     = 8'h3D;
  localparam logic [7:0] CharBang   = 8'h21;
  localparam logic [7:0] CharUnder  = 8'h5F;
  localparam logic [7:0] CharDot    = 8'h2E;

  // token queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_line;
  } in_req_t;

  typedef struct packed {
    tok_kind_e          token_kind;
    logic [TokLenW-1:0] token_length;
    logic               last;
  } out_req_t;

  typedef struct packed {
    tok_kind_e          kind;
    logic [TokLenW-1:0] len;
  } tok_t;

  typedef struct packed {
    logic two;
    tok_t first;
    tok_t second;
  } entry_t;

endpackage

`default_nettype wire

// File: hdl/etl_front.sv
`default_nettype none

module etl_front #(
  parameter int unsigned MaxTokenLen = 63
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  etl_pkg::in_req_t     req_i,
  input  wire                  valid_i,
  output logic                 ready_o,
  input  wire                  full_i,
  output logic                 push_o,
  output etl_pkg::entry_t      entry_o
);

  localparam int unsigned LenW = $clog2(MaxTokenLen + 1);

  etl_pkg::pend_e  pend_q, pend_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] len_grow;

  logic               is_letter, is_digit;
  logic               st_emit;
  etl_pkg::tok_t      st_tok;
  etl_pkg::pend_e     st_pend;

  logic               f_valid;
  etl_pkg::tok_t      f_tok;
  logic               do_flush;
  logic               s_valid;
  etl_pkg::tok_t      s_tok;
  logic               accept;

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;

  assign is_letter = (req_i.ch >= 8'h61 && req_i.ch <= 8'h7A) ||
                     (req_i.ch >= 8'h41 && req_i.ch <= 8'h5A) ||
                     (req_i.ch == etl_pkg::CharUnder);
  assign is_digit  = (req_i.ch >= 8'h30 && req_i.ch <= 8'h39);

  assign len_grow = (len_q < LenW'(MaxTokenLen)) ? len_q + LenW'(1) : len_q;

  // what a character does when no token is pending
  always_comb begin
    st_emit  = 1'b1;
    st_pend  = etl_pkg::PendNone;
    st_tok   = '{kind: etl_pkg::KindError, len: etl_pkg::TokLenW'(1)};
    unique case (req_i.ch)
      etl_pkg::CharSpace, etl_pkg::CharTab: st_emit = 1'b0;
      etl_pkg::CharPlus:   st_tok.kind = etl_pkg::KindPlus;
      etl_pkg::CharMinus:  st_tok.kind = etl_pkg::KindMinus;
      etl_pkg::CharStar:   st_tok.kind = etl_pkg::KindStar;
      etl_pkg::CharSlash:  st_tok.kind = etl_pkg::KindSlash;
      etl_pkg::CharPerc:   st_tok.kind = etl_pkg::KindPerc;
      etl_pkg::CharCaret:  st_tok.kind = etl_pkg::KindCaret;
      etl_pkg::CharOparen: st_tok.kind = etl_pkg::KindOparen;
      etl_pkg::CharCparen: st_tok.kind = etl_pkg::KindCparen;
      etl_pkg::CharLt: begin
        st_emit = 1'b0;
        st_pend = etl_pkg::PendLt;
      end
      etl_pkg::CharGt: begin
        st_emit = 1'b0;
        st_pend = etl_pkg::PendGt;
      end
      etl_pkg::CharEq: begin
        st_emit = 1'b0;
        st_pend = etl_pkg::PendEq;
      end
      etl_pkg::CharBang: begin
        st_emit = 1'b0;
        st_pend = etl_pkg::PendBang;
      end
      default: begin
        if (is_letter) begin
          st_emit = 1'b0;
          st_pend = etl_pkg::PendSym;
        end else if (is_digit) begin
          st_emit = 1'b0;
          st_pend = etl_pkg::PendNum;
        end
      end
    endcase
  end

  // token left behind by the pending state
  always_comb begin
    f_valid = 1'b1;
    f_tok   = '{kind: etl_pkg::KindEnd, len: etl_pkg::TokLenW'(1)};
    unique case (pend_q)
      etl_pkg::PendLt:   f_tok.kind = etl_pkg::KindLt;
      etl_pkg::PendGt:   f_tok.kind = etl_pkg::KindGt;
      etl_pkg::PendEq:   f_tok.kind = etl_pkg::KindAssign;
      etl_pkg::PendBang: f_tok.kind = etl_pkg::KindNot;
      etl_pkg::PendSym: begin
        f_tok.kind = etl_pkg::KindSym;
        f_tok.len  = etl_pkg::TokLenW'(len_q);
      end
      etl_pkg::PendNum: begin
        f_tok.kind = etl_pkg::KindNum;
        f_tok.len  = etl_pkg::TokLenW'(len_q);
      end
      default: f_valid = 1'b0;
    endcase
  end

  always_comb begin
    logic restart;
    restart  = 1'b0;
    do_flush = 1'b0;
    s_valid  = 1'b0;
    s_tok    = '{kind: etl_pkg::KindEnd, len: '0};
    pend_d   = pend_q;
    len_d    = len_q;
    if (req_i.end_of_line) begin
      do_flush = 1'b1;
      s_valid  = 1'b1;
      pend_d   = etl_pkg::PendNone;
      len_d    = '0;
    end else begin
      unique case (pend_q)
        etl_pkg::PendLt, etl_pkg::PendGt, etl_pkg::PendEq, etl_pkg::PendBang: begin
          if (req_i.ch == etl_pkg::CharEq) begin
            s_valid   = 1'b1;
            s_tok.len = etl_pkg::TokLenW'(2);
            pend_d    = etl_pkg::PendNone;
            len_d     = '0;
            unique case (pend_q)
              etl_pkg::PendLt: s_tok.kind = etl_pkg::KindLte;
              etl_pkg::PendGt: s_tok.kind = etl_pkg::KindGte;
              etl_pkg::PendEq: s_tok.kind = etl_pkg::KindEqu;
              default:         s_tok.kind = etl_pkg::KindNequ;
            endcase
          end else begin
            restart = 1'b1;
          end
        end
        etl_pkg::PendSym: begin
          if (is_letter) len_d = len_grow;
          else           restart = 1'b1;
        end
        etl_pkg::PendNum: begin
          if (is_digit || req_i.ch == etl_pkg::CharDot) len_d = len_grow;
          else                                           restart = 1'b1;
        end
        default: restart = 1'b1;
      endcase
      if (restart) begin
        do_flush = 1'b1;
        s_valid  = st_emit;
        s_tok    = st_tok;
        pend_d   = st_pend;
        len_d    = (st_pend != etl_pkg::PendNone) ? LenW'(1) : '0;
      end
    end
  end

  always_comb begin
    entry_o = '0;
    if (do_flush && f_valid) begin
      entry_o.first  = f_tok;
      entry_o.second = s_tok;
      entry_o.two    = s_valid;
    end else begin
      entry_o.first  = s_tok;
    end
  end

  assign push_o = accept && ((do_flush && f_valid) || s_valid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= etl_pkg::PendNone;
      len_q  <= '0;
    end else if (accept) begin
      pend_q <= pend_d;
      len_q  <= len_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/etl_queue.sv
`default_nettype none

module etl_queue (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  etl_pkg::entry_t  entry_i,
  output logic             full_o,
  input  wire              pop_i,
  output logic             nonempty_o,
  output etl_pkg::entry_t  entry_o
);

  etl_pkg::entry_t                 mem_q [etl_pkg::QDepth];
  logic [etl_pkg::QPtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [etl_pkg::QCntW-1:0]       cnt_q;
  logic                            do_pop;

  assign full_o     = (cnt_q == etl_pkg::QCntW'(etl_pkg::QDepth));
  assign nonempty_o = (cnt_q != '0);
  assign entry_o    = mem_q[rd_ptr_q];
  assign do_pop     = pop_i && nonempty_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + etl_pkg::QPtrW'(1);
      if (do_pop) rd_ptr_q <= rd_ptr_q + etl_pkg::QPtrW'(1);
      if (push_i && !do_pop)      cnt_q <= cnt_q + etl_pkg::QCntW'(1);
      else if (!push_i && do_pop) cnt_q <= cnt_q - etl_pkg::QCntW'(1);
    end
  end

endmodule

`default_nettype wire

// File: hdl/etl_back.sv
`default_nettype none

module etl_back (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               nonempty_i,
  input  etl_pkg::entry_t   entry_i,
  output logic              pop_o,
  output etl_pkg::out_req_t req_o,
  output logic              valid_o,
  input  wire               ready_i
);

  logic              sel_q, sel_d;
  logic              valid_q;
  etl_pkg::out_req_t req_q;
  logic              load;
  logic              is_last;
  etl_pkg::tok_t     tok;

  assign load    = nonempty_i && (!valid_q || ready_i);
  assign is_last = sel_q || !entry_i.two;
  assign tok     = sel_q ? entry_i.second : entry_i.first;
  assign pop_o   = load && is_last;

  // second half of a two-token entry is sent on the following slot
  always_comb begin
    sel_d = sel_q;
    if (load) sel_d = !is_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
      if (load)         valid_q <= 1'b1;
      else if (ready_i) valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q.token_kind   <= tok.kind;
      req_q.token_length <= tok.len;
      req_q.last         <= is_last;
    end
  end

  assign req_o   = req_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

// File: hdl/expression_token_lexer.sv
// Streaming lexer for infix expressions: one character (or an end-of-line
// marker) per input request, tokens out with kind, length and a last flag
// marking the final token caused by that request. A request yields zero, one
// or two tokens. The front end takes one request per clock while the queue
// is not full and pushes its tokens as one entry into a 4-entry queue; the
// back end drains one token per clock while out_ready_i is high into a
// registered output. Sustained rate is one request per cycle while each
// request yields at most one token and out_ready_i stays high; a request
// that yields two (a flushed token followed by another, or a token followed
// by END) sends them in turn, so the output port sets the rate then. Lengths
// saturate at MaxTokenLen, reported in 6 bits. No clearing pass after reset.
`default_nettype none

module expression_token_lexer #(
  parameter int unsigned MaxTokenLen = 63
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  etl_pkg::in_req_t  in_req_i,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  output etl_pkg::out_req_t out_req_o,
  output logic              out_valid_o,
  input  wire               out_ready_i
);

  logic            q_full, q_push, q_pop, q_nonempty;
  etl_pkg::entry_t q_wdata, q_rdata;

  etl_front #(
    .MaxTokenLen(MaxTokenLen)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (in_req_i),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .full_i  (q_full),
    .push_o  (q_push),
    .entry_o (q_wdata)
  );

  etl_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .entry_i    (q_wdata),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .nonempty_o (q_nonempty),
    .entry_o    (q_rdata)
  );

  etl_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .nonempty_i (q_nonempty),
    .entry_i    (q_rdata),
    .pop_o      (q_pop),
    .req_o      (out_req_o),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i)
  );

endmodule

`default_nettype wire
